@@ sv/pf_pkg.sv @@
// Shared widths and state codes for the prime factorizer.
package pf_pkg;

  // Width of the number being factored.
  localparam int VALUE_W = 32;
  // Trial divisors never exceed the square root of the value, plus one odd step.
  localparam int DIV_W = VALUE_W / 2 + 1;
  // Width of a reported prime.
  localparam int PRIME_W = 32;
  // Width and ceiling of a reported exponent.
  localparam int EXP_W = 5;
  localparam logic [EXP_W-1:0] EXP_MAX = '1;
  // Most results one value can produce.
  localparam int MAX_RESULTS = 9;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  // Cycle counter for the bit-serial divider.
  localparam int DCNT_W = $clog2(VALUE_W);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(VALUE_W - 1);

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_EVAL  = 6'b000100,
    ST_STORE = 6'b001000,
    ST_FINAL = 6'b010000,
    ST_LAST  = 6'b100000
  } pf_state_t;

endpackage

@@ sv/prime_factorizer.sv @@
// Top level of the trial-division prime factorizer.
//
// The block takes one unsigned 32-bit value and returns one item per distinct
// prime factor, in ascending order, each with its exponent; the final item of
// a value has last set. Values 0 and 1 return a single item with none set and
// prime and exponent zero. A single bit-serial restoring divider does all the
// work: every trial of a divisor (2, then 3, 5, 7, ...) is a division and then
// an evaluation of quotient and remainder, and the search stops as soon as the
// divisor exceeds the quotient or nine results are found. A value with only
// small factors finishes far sooner than a prime near 2^32, which needs about
// 32768 trials. The input is not ready while a value is being factored.
// Results wait in an output register and a one-entry pending register, so a
// stalled consumer only pauses the search when a third result is found.
module prime_factorizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pf_pkg::VALUE_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pf_pkg::PRIME_W-1:0] prime,
  output logic [pf_pkg::EXP_W-1:0]   exponent,
  output logic                       none,
  output logic                       last
);
  import pf_pkg::*;

  pf_state_t state;

  // Working values of the search.
  logic [VALUE_W-1:0] remaining;
  logic [DIV_W-1:0]   trial_divisor;
  logic [EXP_W-1:0]   multiplicity;
  logic               testing;
  logic [CNT_W-1:0]   found;

  // Divider registers: partial remainder, dividend shifting into quotient.
  logic [DIV_W-1:0]   part;
  logic [VALUE_W-1:0] quo;
  logic [DCNT_W-1:0]  dcnt;

  // One result held back until it is known whether it is the final one.
  logic               pend_v;
  logic [PRIME_W-1:0] pend_prime;
  logic [EXP_W-1:0]   pend_exp;
  logic               pend_none;

  logic [DIV_W:0]     shifted;
  logic               sub_ok;
  logic [DIV_W:0]     diff;
  logic [DIV_W-1:0]   part_next;
  logic [VALUE_W-1:0] quo_next;
  logic               slot_free;
  logic               loop_done;
  logic               rem_hit;
  logic [DIV_W-1:0]   divisor_next;
  logic [EXP_W-1:0]   mult_inc;
  logic               final_prime;

  // One restoring division step per cycle.
  always_comb begin
    shifted   = {part, quo[VALUE_W-1]};
    sub_ok    = shifted >= {1'b0, trial_divisor};
    diff      = shifted - {1'b0, trial_divisor};
    part_next = sub_ok ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    quo_next  = {quo[VALUE_W-2:0], sub_ok};
  end

  // Decisions taken once a division has finished.
  always_comb begin
    loop_done    = ({{(VALUE_W-DIV_W){1'b0}}, trial_divisor} > quo) ||
                   (found == CNT_W'(MAX_RESULTS));
    rem_hit      = (part == '0);
    divisor_next = (trial_divisor == DIV_W'(2)) ? DIV_W'(3) : trial_divisor + DIV_W'(2);
    mult_inc     = (multiplicity == EXP_MAX) ? multiplicity : multiplicity + EXP_W'(1);
    final_prime  = (remaining > VALUE_W'(1)) && (found < CNT_W'(MAX_RESULTS));
  end

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Sequencer, divider and result registers.
  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          remaining     <= value;
          trial_divisor <= DIV_W'(2);
          multiplicity  <= '0;
          testing       <= 1'b1;
          found         <= '0;
          part          <= '0;
          quo           <= value;
          dcnt          <= '0;
          if (value < VALUE_W'(2)) begin
            pend_v     <= 1'b1;
            pend_prime <= '0;
            pend_exp   <= '0;
            pend_none  <= 1'b1;
            state      <= ST_LAST;
          end else begin
            pend_v <= 1'b0;
            state  <= ST_DIV;
          end
        end
      end
      ST_DIV: begin
        part <= part_next;
        quo  <= quo_next;
        dcnt <= dcnt + DCNT_W'(1);
        if (dcnt == DCNT_LAST) begin
          state <= ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (testing && loop_done) begin
          state <= ST_FINAL;
        end else if (rem_hit) begin
          // Divisor goes in: divide it out again.
          remaining    <= quo;
          multiplicity <= mult_inc;
          testing      <= 1'b0;
          part         <= '0;
          dcnt         <= '0;
          state        <= ST_DIV;
        end else if (!testing) begin
          state <= ST_STORE;
        end else begin
          trial_divisor <= divisor_next;
          part          <= '0;
          quo           <= remaining;
          dcnt          <= '0;
          state         <= ST_DIV;
        end
      end
      ST_STORE: begin
        // Park the new factor; the older pending one moves to the output.
        if (!pend_v || slot_free) begin
          if (pend_v) begin
            out_valid <= 1'b1;
            prime     <= pend_prime;
            exponent  <= pend_exp;
            none      <= pend_none;
            last      <= 1'b0;
          end
          pend_v        <= 1'b1;
          pend_prime    <= {{(PRIME_W-DIV_W){1'b0}}, trial_divisor};
          pend_exp      <= multiplicity;
          pend_none     <= 1'b0;
          found         <= found + CNT_W'(1);
          trial_divisor <= divisor_next;
          multiplicity  <= '0;
          testing       <= 1'b1;
          part          <= '0;
          quo           <= remaining;
          dcnt          <= '0;
          state         <= ST_DIV;
        end
      end
      ST_FINAL: begin
        // A cofactor above one is itself the largest prime.
        if (!final_prime) begin
          state <= ST_LAST;
        end else if (!pend_v || slot_free) begin
          if (pend_v) begin
            out_valid <= 1'b1;
            prime     <= pend_prime;
            exponent  <= pend_exp;
            none      <= pend_none;
            last      <= 1'b0;
          end
          pend_v     <= 1'b1;
          pend_prime <= PRIME_W'(remaining);
          pend_exp   <= EXP_W'(1);
          pend_none  <= 1'b0;
          found      <= found + CNT_W'(1);
          remaining  <= VALUE_W'(1);
          state      <= ST_LAST;
        end
      end
      ST_LAST: begin
        if (slot_free) begin
          out_valid <= 1'b1;
          prime     <= pend_prime;
          exponent  <= pend_exp;
          none      <= pend_none;
          last      <= 1'b1;
          pend_v    <= 1'b0;
          state     <= ST_IDLE;
        end
      end
      default: begin
        state <= ST_IDLE;
      end
    endcase
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end
  end

endmodule

@@ sv/pf_checker.sv @@
// Port-level checks for the prime factorizer and their binding.
module pf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pf_pkg::PRIME_W-1:0] prime,
  input logic [pf_pkg::EXP_W-1:0]   exponent,
  input logic                       none,
  input logic                       last
);
  import pf_pkg::*;

  // A result held by a stalled consumer does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prime) && $stable(exponent) &&
      $stable(none) && $stable(last))
    else $error("output item changed while stalled");

  // A value with no factors gives one final, empty item.
  a_none_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && none |-> last && prime == '0 && exponent == '0)
    else $error("none item malformed");

  // A real factor is at least two with a nonzero exponent.
  a_factor_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !none |-> prime >= PRIME_W'(2) && exponent != '0)
    else $error("factor item malformed");

  // Accepting a value makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  // While ready for a new value, no non-final item of the last one waits.
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(out_valid && !last))
    else $error("ready with an unfinished factorization");

endmodule

bind prime_factorizer pf_checker u_pf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .prime     (prime),
  .exponent  (exponent),
  .none      (none),
  .last      (last)
);

@@ dv/tb_prime_factorizer.sv @@
// Self-checking testbench for the trial-division prime factorizer.
`timescale 1ns / 100ps

module tb_prime_factorizer;
  import pf_pkg::*;

  // One reported factor: prime, multiplicity, no-factor flag and end-of-value mark.
  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    logic               no_factor;
    logic               last;
  } factor_t;

  // Keeps the factors still due from the block and compares what comes out.
  class factor_board;
    factor_t     due_factors[$];
    int unsigned errors;
    int unsigned values_seen;
    int unsigned factors_checked;
    int unsigned most_primes;
    int unsigned top_exponent;
    int unsigned no_factor_values;

    function new();
      errors = 0;
      values_seen = 0;
      factors_checked = 0;
      most_primes = 0;
      top_exponent = 0;
      no_factor_values = 0;
    endfunction

    // Factor an accepted value by trial division and queue the factors it yields.
    function void note_value(logic [VALUE_W-1:0] v);
      longint unsigned rem;
      longint unsigned div;
      int unsigned     mult;
      factor_t         run[$];
      factor_t         f;
      values_seen++;
      rem = 64'(v);
      if (rem < 2) begin
        f = '{prime: '0, exponent: '0, no_factor: 1'b1, last: 1'b1};
        due_factors.push_back(f);
        no_factor_values++;
        return;
      end
      div = 2;
      while (div <= rem / div && run.size() < MAX_RESULTS) begin
        mult = 0;
        while (rem % div == 0) begin
          rem = rem / div;
          mult++;
        end
        if (mult != 0) begin
          f.prime = div[PRIME_W-1:0];
          f.exponent = (mult > EXP_MAX) ? EXP_MAX : mult[EXP_W-1:0];
          f.no_factor = 1'b0;
          f.last = 1'b0;
          run.push_back(f);
          if (mult > top_exponent) top_exponent = mult;
        end
        div = (div == 2) ? 3 : div + 2;
      end
      // Whatever is left above one is itself prime.
      if (rem > 1 && run.size() < MAX_RESULTS) begin
        f.prime = rem[PRIME_W-1:0];
        f.exponent = EXP_W'(1);
        f.no_factor = 1'b0;
        f.last = 1'b0;
        run.push_back(f);
      end
      run[run.size() - 1].last = 1'b1;
      if (run.size() > most_primes) most_primes = run.size();
      foreach (run[i]) due_factors.push_back(run[i]);
    endfunction

    // Compare one item from the block with the oldest factor still due.
    function void check_result(logic [PRIME_W-1:0] prime, logic [EXP_W-1:0] exponent,
                               logic no_factor, logic last);
      factor_t want;
      if (due_factors.size() == 0) begin
        $error("unexpected factor item: prime %0d exponent %0d none %0b last %0b",
               prime, exponent, no_factor, last);
        errors++;
        return;
      end
      want = due_factors.pop_front();
      factors_checked++;
      if (prime !== want.prime) begin
        $error("prime: expected %0d, got %0d", want.prime, prime);
        errors++;
      end
      if (exponent !== want.exponent) begin
        $error("exponent: expected %0d, got %0d", want.exponent, exponent);
        errors++;
      end
      if (no_factor !== want.no_factor) begin
        $error("none: expected %0b, got %0b", want.no_factor, no_factor);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return due_factors.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PRIME_W-1:0] prime;
  logic [EXP_W-1:0]   exponent;
  logic               none;
  logic               last;

  factor_board board;
  // While set, neither side inserts idle cycles.
  bit          steady = 1'b0;

  prime_factorizer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .prime     (prime),
    .exponent  (exponent),
    .none      (none),
    .last      (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Number of remainder trials the search spends on a value, stopping at cap.
  function automatic int unsigned search_cost(longint unsigned v, int unsigned cap);
    longint unsigned rem;
    longint unsigned div;
    int unsigned     trials;
    rem = v;
    trials = 0;
    div = 2;
    while (rem >= 2 && div <= rem / div && trials < cap) begin
      trials++;
      while (rem % div == 0 && trials < cap) begin
        rem = rem / div;
        trials++;
      end
      div = (div == 2) ? 3 : div + 2;
    end
    return trials;
  endfunction

  // A random product of small primes, so that exponents and prime counts vary.
  function automatic logic [VALUE_W-1:0] smooth_value();
    int unsigned     small_primes[20] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29,
                                          31, 37, 41, 43, 47, 53, 59, 61, 67, 71};
    longint unsigned acc;
    longint unsigned q;
    int unsigned     steps;
    acc = 1;
    steps = $urandom_range(1, 30);
    repeat (steps) begin
      q = 64'(small_primes[$urandom_range(19)]);
      if (acc * q <= 64'hFFFF_FFFF) acc = acc * q;
    end
    return acc[VALUE_W-1:0];
  endfunction

  // A full-width random value whose search stays short enough for the run.
  function automatic logic [VALUE_W-1:0] short_search_value();
    logic [VALUE_W-1:0] v;
    do begin
      v = $urandom;
    end while (search_cost(64'(v), 400) >= 400);
    return v;
  endfunction

  // Offer one value, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_value(v);
  endtask

  // Result side: check each accepted item, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result(prime, exponent, none, last);
    end
    out_ready <= steady || ($urandom_range(99) >= 7);
  end

  initial begin
    logic [VALUE_W-1:0] corner[$];
    int unsigned        pick;
    board = new();
    corner = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd30, 32'd49,
               32'd1018081,      // square of a prime
               32'h8000_0000,    // highest exponent
               32'hFFFF_FFFF,    // all ones, five distinct primes
               32'd223092870,    // nine distinct primes
               32'd446185740,    // nine distinct primes, two squared
               32'd3486784401,   // a high power of three
               32'd2000006,      // large prime left over after the search
               32'd4293984256,   // power of two times a 16-bit prime
               32'd4294967291};  // largest 32-bit prime, the slowest search

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed corners.
    foreach (corner[i]) send_value(corner[i]);

    // Random values: full-width values with short searches, smooth products,
    // and small numbers.
    for (int n = 0; n < 100; n++) begin
      steady = (n >= 20 && n < 45);
      if (n == 60) begin
        // Hold the input back until every due factor has come out.
        in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 45) send_value(short_search_value());
      else if (pick < 80) send_value(smooth_value());
      else send_value($urandom_range(2000));
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // Drain, then give the block time to show any stray item.
    while (board.outstanding() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Factored %0d values (%0d without prime factors) into %0d checked items.",
             board.values_seen, board.no_factor_values, board.factors_checked);
    $display("Up to %0d distinct primes per value, highest exponent %0d.",
             board.most_primes, board.top_exponent);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("prime_factorizer: match");
    end else begin
      if (board.outstanding() != 0) begin
        $error("%0d expected factor items never arrived", board.outstanding());
      end
      $display("prime_factorizer: mismatch");
    end
    $finish;
  end

  // Hang guard, several times the slowest expected run.
  initial begin
    #(64'd32_000_000);
    $display("Timed out with %0d factor items still due.", board.outstanding());
    $display("prime_factorizer: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
sv/pf_pkg.sv
sv/prime_factorizer.sv
sv/pf_checker.sv
dv/tb_prime_factorizer.sv
